@@ rtl/kfct_pkg.sv @@
// Package for the key frequency count table: command codes, result kinds and controller states.
package kfct_pkg;

  // Command codes carried on s_tuser
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // ignored, no results

  // Result kinds carried on m_tuser
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_REC_RD  = 7'b0000010,
    ST_REC_CMP = 7'b0000100,
    ST_REC_END = 7'b0001000,
    ST_SC_RD   = 7'b0010000,
    ST_SC_CMP  = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_t;

endpackage

@@ rtl/key_frequency_count_table.sv @@
// Key frequency count table: counts keys and reports them sorted by count.
//
// Input channel (s_*): one transfer is one command. s_tuser is the command
// (record, report, clear), s_tdata the key used by record.
// Output channel (m_*): m_tdata holds key and count, m_tuser the kind
// (report entry or dropped record), m_tlast marks the final result of a command.
// Record walks the used entries through the key and count RAMs (registered
// read) until it finds the key and updates its count, or else appends it. A
// record of an unknown key into a full table gives one dropped result. Report
// runs one scan over the used entries per result, picking the highest count
// not yet sent, earliest entry on ties: n results for n used entries. Clear
// empties the table without leaving the idle state.
// One command is worked on at a time; s_tready is high only while idle.
// A stalled receiver holds the result register and the scan waits for it.
// Reset empties the table at once; the RAMs need no clearing.
module key_frequency_count_table
  import kfct_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] entry_key, [63:32] entry_count
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);

  localparam int AW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);

  state_t                state;
  logic [UW-1:0]         used;
  logic [UW-1:0]         ptr;
  logic [UW-1:0]         remaining;
  logic [KEY_BITS-1:0]   key_r;
  logic [ENTRIES-1:0]    done;
  logic                  have_best;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [KEY_BITS-1:0]   best_key;
  logic [AW-1:0]         best_idx;

  // RAM ports
  logic                  key_we, cnt_we;
  logic [AW-1:0]         waddr, raddr;
  logic [KEY_BITS-1:0]   key_wdata, key_rd;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;

  logic                  s_fire;
  logic [KEY_BITS+31:0]  key_in_ext;
  logic [KEY_BITS-1:0]   key_in;
  logic [KEY_BITS+31:0]  best_key_ext;
  logic [COUNT_BITS+31:0] best_cnt_ext;

  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign key_in_ext = {{KEY_BITS{1'b0}}, s_tdata};
  assign key_in     = key_in_ext[KEY_BITS-1:0];
  assign best_key_ext = {32'd0, best_key};
  assign best_cnt_ext = {32'd0, best_cnt};

  kfct_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rd)
  );

  kfct_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(raddr), .rdata(cnt_rd)
  );

  // RAM access: read at the walk pointer, write on hit or append
  always_comb begin
    raddr     = ptr[AW-1:0];
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = ptr[AW-1:0];
    key_wdata = key_r;
    cnt_wdata = cnt_rd;
    if (state == ST_REC_CMP && key_rd == key_r) begin
      cnt_we    = 1'b1;
      cnt_wdata = (cnt_rd == {COUNT_BITS{1'b1}}) ? cnt_rd : cnt_rd + 1'b1;
    end else if (state == ST_REC_END && used < UW'(ENTRIES)) begin
      key_we    = 1'b1;
      cnt_we    = 1'b1;
      waddr     = used[AW-1:0];
      cnt_wdata = COUNT_BITS'(1);
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            key_r     <= key_in;
            ptr       <= '0;
            have_best <= 1'b0;
            done      <= '0;
            remaining <= used;
            case (s_tuser)
              CMD_RECORD: state <= ST_REC_RD;
              CMD_REPORT: if (used != '0) state <= ST_SC_RD;
              CMD_CLEAR:  used <= '0;
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_REC_RD: begin
          state <= (ptr == used) ? ST_REC_END : ST_REC_CMP;
        end
        ST_REC_CMP: begin
          if (key_rd == key_r) begin
            state <= ST_IDLE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= ST_REC_RD;
          end
        end
        ST_REC_END: begin
          if (used < UW'(ENTRIES)) begin
            used  <= used + 1'b1;
            state <= ST_IDLE;
          end else begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_DROPPED;
            m_tdata  <= {32'd0, key_r_low()};
            m_tlast  <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_SC_RD: begin
          if (ptr == used) begin
            // scan over: send the best entry not yet reported
            m_tvalid       <= 1'b1;
            m_tuser        <= KIND_ENTRY;
            m_tdata        <= {best_cnt_ext[31:0], best_key_ext[31:0]};
            m_tlast        <= (remaining == UW'(1));
            done[best_idx] <= 1'b1;
            remaining      <= remaining - 1'b1;
            state          <= ST_OUT;
          end else begin
            state <= ST_SC_CMP;
          end
        end
        ST_SC_CMP: begin
          if (!done[ptr[AW-1:0]] && (!have_best || cnt_rd > best_cnt)) begin
            have_best <= 1'b1;
            best_cnt  <= cnt_rd;
            best_key  <= key_rd;
            best_idx  <= ptr[AW-1:0];
          end
          ptr   <= ptr + 1'b1;
          state <= ST_SC_RD;
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid  <= 1'b0;
            ptr       <= '0;
            have_best <= 1'b0;
            state     <= m_tlast ? ST_IDLE : ST_SC_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Low 32 bits of the held key for a dropped result
  function automatic logic [31:0] key_r_low();
    logic [KEY_BITS+31:0] ext;
    ext = {32'd0, key_r};
    return ext[31:0];
  endfunction

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(ENTRIES)) else $error("entry count above table size");
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("result pending while idle");
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DROPPED) |-> (m_tlast && m_tdata[63:32] == 32'd0))
    else $error("malformed dropped result");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_CLEAR) |=> (used == '0))
    else $error("clear did not empty table");
`endif

endmodule

@@ rtl/kfct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module kfct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ verif/key_frequency_count_table_tb.sv @@
// Self-checking testbench for the key frequency count table: directed rows, then random traffic.
`timescale 1ns / 1ps

module key_frequency_count_table_tb;
  import kfct_pkg::*;

  localparam int ENTRIES    = 64;
  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int TAIL       = 400;   // settle time after the last expected result

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [31:0] count;
    logic        last;
  } table_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    bit          typed;   // expectation typed in the row, not predicted
    bit          has_res; // typed row gives one result
    table_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] entry_key, [63:32] entry_count
  logic        m_tuser;        // [0] kind
  logic        m_tlast;

  // Predictor state
  logic [31:0]   model_keys[ENTRIES];
  logic [31:0]   model_counts[ENTRIES];
  int            model_used;
  table_result_t pending_results[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  int  rx_stall = 0;

  key_frequency_count_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Update the table copy and queue the results a command causes
  function automatic void predict_table(logic [1:0] cmd, logic [31:0] key, bit keep);
    bit            hit;
    bit            sent[ENTRIES];
    int            best;
    table_result_t r;
    hit = 1'b0;
    if (cmd == CMD_RECORD) begin
      for (int i = 0; i < model_used; i++) begin
        if (!hit && model_keys[i] == key) begin
          hit = 1'b1;
          if (model_counts[i] != 32'hFFFF_FFFF) model_counts[i] = model_counts[i] + 1;
        end
      end
      if (!hit) begin
        if (model_used < ENTRIES) begin
          model_keys[model_used]   = key;
          model_counts[model_used] = 32'd1;
          model_used++;
        end else if (keep) begin
          r = '{kind: KIND_DROPPED, key: key, count: 32'd0, last: 1'b1};
          pending_results.push_back(r);
        end
      end
    end else if (cmd == CMD_REPORT) begin
      for (int i = 0; i < ENTRIES; i++) sent[i] = 1'b0;
      // highest count first, earliest entry on ties
      for (int n = 0; n < model_used; n++) begin
        best = -1;
        for (int i = 0; i < model_used; i++)
          if (!sent[i] && (best < 0 || model_counts[i] > model_counts[best])) best = i;
        sent[best] = 1'b1;
        r = '{kind: KIND_ENTRY, key: model_keys[best], count: model_counts[best],
              last: (n == model_used - 1)};
        if (keep) pending_results.push_back(r);
      end
    end else if (cmd == CMD_CLEAR) begin
      model_used = 0;
    end
  endfunction

  // Present one command and wait for its transfer
  task automatic send_command(logic [1:0] cmd, logic [31:0] key, bit typed = 1'b0,
                              bit has_res = 1'b0, table_result_t res = '0);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    predict_table(cmd, key, !typed);
    if (typed && has_res) pending_results.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stalls in bursts
  always @(negedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      rx_stall <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d key %h count %0d", m_tuser, m_tdata[31:0],
               m_tdata[63:32]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser);
          mismatches++;
        end
        if (m_tdata[31:0] !== want.key) begin
          $error("entry_key: expected %h, got %h", want.key, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[63:32] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_tdata[63:32]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t   directed[$];
  logic [31:0] key_pool[$];
  int          pool_size;
  int          run_len;

  initial begin
    model_used = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      model_keys[i]   = '0;
      model_counts[i] = '0;
    end

    // Directed rows; typed ones carry their expectation
    directed = '{
      '{CMD_REPORT, 32'h0000_0000, 1, 0, '0},            // empty table reports nothing
      '{CMD_RECORD, 32'h0000_0000, 1, 0, '0},
      '{CMD_RECORD, 32'hFFFF_FFFF, 1, 0, '0},
      '{CMD_RECORD, 32'h0000_0000, 1, 0, '0},
      '{CMD_UNUSED, 32'h1234_5678, 1, 0, '0},            // unused command is ignored
      '{CMD_REPORT, 32'h0000_0000, 0, 0, '0},
      '{CMD_CLEAR,  32'hFFFF_FFFF, 1, 0, '0},
      '{CMD_REPORT, 32'hFFFF_FFFF, 1, 0, '0},            // cleared table is empty
      '{CMD_RECORD, 32'hAAAA_AAAA, 1, 0, '0},
      '{CMD_RECORD, 32'h5555_5555, 1, 0, '0},
      '{CMD_RECORD, 32'h5555_5555, 1, 0, '0},
      '{CMD_RECORD, 32'h8000_0001, 1, 0, '0},
      '{CMD_RECORD, 32'hAAAA_AAAA, 1, 0, '0},
      '{CMD_RECORD, 32'h8000_0001, 1, 0, '0},            // three-way tie at two
      '{CMD_REPORT, 32'h0000_0000, 0, 0, '0},
      '{CMD_RECORD, 32'h8000_0001, 1, 0, '0},
      '{CMD_REPORT, 32'h0000_0000, 0, 0, '0},
      '{CMD_CLEAR,  32'h0000_0000, 1, 0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i])
      send_command(directed[i].cmd, directed[i].key, directed[i].typed,
                   directed[i].has_res, directed[i].res);

    // Random part: mostly clear-record-report runs over a key pool, some noise
    while (items_sent < 440) begin
      if (items_sent > 380) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_command(2'($urandom_range(0, 3)), $urandom);
      end else begin
        pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 80)
                                                : $urandom_range(1, 12);
        key_pool.delete();
        for (int i = 0; i < pool_size; i++)
          key_pool.push_back($urandom_range(0, 7) == 0 ? {32{1'($urandom)}} : $urandom);
        run_len = (pool_size > 40) ? $urandom_range(pool_size, pool_size + 20)
                                   : $urandom_range(3, 25);
        send_command(CMD_CLEAR, $urandom);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 24) == 0) send_command(CMD_REPORT, $urandom);
          else send_command(CMD_RECORD, key_pool[$urandom_range(0, pool_size - 1)]);
        end
        send_command(CMD_REPORT, $urandom);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
